// ===== rtl/core/csvfs_pkg.sv =====
`default_nettype none
package csvfs_pkg;

  localparam logic [7:0] QUOTE_BYTE   = 8'h22;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] NUL_BYTE     = 8'h00;
  localparam logic [15:0] LENGTH_MAX  = 16'hFFFF;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_END      = 2'd2;

  localparam logic [1:0] REG_DELIMITER    = 2'd0;
  localparam logic [1:0] REG_FIRST_COLUMN = 2'd1;
  localparam logic [1:0] REG_LAST_COLUMN  = 2'd2;
  localparam logic [1:0] REG_ALL_COLUMNS  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] row_number;
    logic [7:0]  column_number;
    logic [31:0] field_offset;
    logic [15:0] field_length;
    logic        selected;
    logic        row_end;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] delimiter;
    logic [7:0] first_column;
    logic [7:0] last_column;
    logic       all_columns;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/csvfs_tokenizer.sv =====
`default_nettype none
module csvfs_tokenizer #(
  parameter int MAX_COLUMNS   = 256,
  parameter int MAX_ROW_COUNT = 65536,
  parameter int OFFSET_BITS   = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire csvfs_pkg::in_item_t item,
  input  wire csvfs_pkg::cfg_t     cfg,
  output logic                    has_result,
  output csvfs_pkg::out_item_t    result
);
  import csvfs_pkg::*;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROW_COUNT);
  localparam int CMP_W = COL_W + 8;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROW_COUNT - 1);

  logic                   quote_open;
  logic [COL_W-1:0]       column_index;
  logic [ROW_W-1:0]       row_index;
  logic [COL_W:0]         columns_per_row;
  logic [OFFSET_BITS-1:0] stream_offset;
  logic [OFFSET_BITS-1:0] field_start;
  logic [15:0]            field_bytes;

  logic                   is_nul;
  logic                   is_nl;
  logic                   is_quote;
  logic                   is_delim;
  logic                   ends;
  logic                   eod;
  logic [OFFSET_BITS-1:0] offset_next;
  logic [15:0]            bytes_next;
  logic [COL_W:0]         column_count;
  logic [COL_W:0]         columns_per_row_next;
  logic                   mismatch;
  logic                   selected;
  logic [CMP_W-1:0]       col_cmp;
  logic [ROW_W+15:0]      row_ext;
  logic [COL_W+7:0]       col_ext;
  logic [OFFSET_BITS+31:0] start_ext;
  logic [OFFSET_BITS+31:0] offset_ext;

  assign eod      = item.end_of_data;
  assign is_nul   = item.data_byte == NUL_BYTE;
  assign is_nl    = item.data_byte == NEWLINE_BYTE;
  assign is_quote = item.data_byte == QUOTE_BYTE;
  assign is_delim = (item.data_byte == cfg.delimiter) && !quote_open && !is_nul && !is_nl
                    && !is_quote;
  assign ends     = !eod && (is_nul || is_nl || is_delim);

  assign offset_next = stream_offset + OFFSET_BITS'(~&stream_offset);
  assign bytes_next  = field_bytes + 16'(field_bytes != LENGTH_MAX);

  assign column_count         = {1'b0, column_index} + (COL_W + 1)'(1);
  assign columns_per_row_next = (columns_per_row == '0) ? column_count : columns_per_row;
  assign mismatch             = column_count != columns_per_row_next;

  assign col_cmp  = CMP_W'(column_index);
  assign selected = (col_cmp >= CMP_W'(cfg.first_column))
                    && (cfg.all_columns || (col_cmp <= CMP_W'(cfg.last_column)));

  assign row_ext    = (ROW_W + 16)'(row_index);
  assign col_ext    = (COL_W + 8)'(column_index);
  assign start_ext  = (OFFSET_BITS + 32)'(field_start);
  assign offset_ext = (OFFSET_BITS + 32)'(stream_offset);

  assign has_result = eod || ends;

  always_comb begin
    result               = '0;
    result.row_number    = row_ext[15:0];
    result.column_number = col_ext[7:0];
    if (eod) begin
      result.field_offset = offset_ext[31:0];
      result.status       = STATUS_END;
    end else begin
      result.field_offset = start_ext[31:0];
      result.field_length = bytes_next;
      result.selected     = selected;
      result.row_end      = is_nl;
      result.status       = (is_nl && mismatch) ? STATUS_MISMATCH : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_open      <= 1'b0;
      column_index    <= '0;
      row_index       <= '0;
      columns_per_row <= '0;
      stream_offset   <= '0;
      field_start     <= '0;
      field_bytes     <= '0;
    end else if (fire) begin
      if (eod) begin
        field_bytes <= '0;
        quote_open  <= 1'b0;
        field_start <= stream_offset;
      end else begin
        stream_offset <= offset_next;
        if (ends) begin
          field_start <= offset_next;
          field_bytes <= '0;
          quote_open  <= 1'b0;
          if (is_nl) begin
            column_index    <= '0;
            columns_per_row <= columns_per_row_next;
            if (row_index != ROW_LAST) begin
              row_index <= row_index + ROW_W'(1);
            end
          end else if (column_index != COL_LAST) begin
            column_index <= column_index + COL_W'(1);
          end
        end else begin
          field_bytes <= bytes_next;
          if (is_quote) begin
            quote_open <= ~quote_open;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/csv_field_splitter_core.sv =====
`default_nettype none
// Delimited-text field splitter, one byte per request.
// Input channel: in_valid / in_stall carry one byte or an end-of-data mark.
// Output channel: out_valid / out_stall carry one record per finished field
// (row, column, start offset, length with terminator, window select, row end,
// status) and one record with end status for each end-of-data request.
// Bytes that do not close a field produce no output request.
// Configuration: cfg_write with cfg_index and cfg_data sets the delimiter and
// the column window; write only while the block is idle.
// A request taken on the input channel waits in the input register, then its
// result is loaded into the result register that drives out_*.
// Throughput: one byte per cycle, sustained, as long as out_stall stays low.
// When the receiver stalls, the result register holds; bytes that close no
// field keep flowing, and the next field-closing request waits in the input
// register with in_stall high until the result register is taken.
// Reset clears all counters, the learned column count and the quote flag, and sets
// the configuration to defaults (delimiter comma, whole window selected); both channels empty.
module csv_field_splitter_core #(
  parameter int MAX_COLUMNS   = 256,
  parameter int MAX_ROW_COUNT = 65536,
  parameter int OFFSET_BITS   = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire csvfs_pkg::in_item_t in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output csvfs_pkg::out_item_t     out_data,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data
);
  import csvfs_pkg::*;

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      s1_adv;
  logic      out_free;
  logic      has_result;
  out_item_t result;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && (!has_result || out_free);
  assign in_stall = s1_valid && !s1_adv;

  csvfs_tokenizer #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROW_COUNT(MAX_ROW_COUNT),
    .OFFSET_BITS  (OFFSET_BITS)
  ) u_tokenizer (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_adv),
    .item      (s1_item),
    .cfg       (cfg),
    .has_result(has_result),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delimiter    <= 8'd44;
      cfg.first_column <= 8'd0;
      cfg.last_column  <= 8'd255;
      cfg.all_columns  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DELIMITER:    cfg.delimiter    <= cfg_data;
        REG_FIRST_COLUMN: cfg.first_column <= cfg_data;
        REG_LAST_COLUMN:  cfg.last_column  <= cfg_data;
        REG_ALL_COLUMNS:  cfg.all_columns  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_result) begin
      out_data <= result;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && has_result && out_valid && out_stall)
    else $error("input stalled without a blocked request");

  a_eod_reaches_output: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_item.end_of_data |=> out_valid && out_data.status == STATUS_END)
    else $error("end-of-data request lost");

  a_end_record_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_END |->
      out_data.field_length == '0 && !out_data.selected && !out_data.row_end)
    else $error("end record carries field data");

  a_field_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != STATUS_END |-> out_data.field_length != '0)
    else $error("field record with zero length");

  a_mismatch_at_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STATUS_MISMATCH |-> out_data.row_end)
    else $error("column mismatch outside row end");

endmodule
`default_nettype wire

// ===== tb/sv/tb_csv_field_splitter_core.sv =====
module tb_csv_field_splitter_core;
  import csvfs_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = REG_DELIMITER;
  logic [7:0] cfg_data = 8'd0;

  csv_field_splitter_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // splitter shadow: configuration
  logic [7:0] sep_byte = 8'd44;
  logic [7:0] win_first = 8'd0;
  logic [7:0] win_last = 8'd255;
  logic win_all = 1'b1;

  // splitter shadow: scan state
  logic in_quotes = 1'b0;
  logic [7:0] col_at = 8'd0;
  logic [15:0] row_at = 16'd0;
  logic [8:0] row_width = 9'd0;
  logic [31:0] byte_pos = 32'd0;
  logic [31:0] field_begin = 32'd0;
  logic [15:0] field_len = 16'd0;

  out_item_t fields_due[$];
  out_item_t oldest;
  int errors = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;

  function automatic void predict_fields(input in_item_t item);
    out_item_t rec;
    logic closes;
    logic newline;
    rec = '0;
    closes = 1'b0;
    newline = 1'b0;
    if (item.end_of_data) begin
      rec.row_number = row_at;
      rec.column_number = col_at;
      rec.field_offset = byte_pos;
      rec.status = STATUS_END;
      fields_due.push_back(rec);
      field_len = 16'd0;
      in_quotes = 1'b0;
      field_begin = byte_pos;
      return;
    end
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
    if (field_len != LENGTH_MAX) field_len++;
    if (item.data_byte == NUL_BYTE) begin
      closes = 1'b1;
    end else if (item.data_byte == NEWLINE_BYTE) begin
      closes = 1'b1;
      newline = 1'b1;
    end else if (item.data_byte == QUOTE_BYTE) begin
      in_quotes = !in_quotes;
    end else if (item.data_byte == sep_byte && !in_quotes) begin
      closes = 1'b1;
    end
    if (!closes) return;
    rec.row_number = row_at;
    rec.column_number = col_at;
    rec.field_offset = field_begin;
    rec.field_length = field_len;
    rec.selected = (col_at >= win_first) && (win_all || col_at <= win_last);
    rec.row_end = newline;
    rec.status = STATUS_OK;
    if (newline) begin
      if (row_width == 9'd0) row_width = {1'b0, col_at} + 9'd1;
      if ({1'b0, col_at} != row_width - 9'd1) rec.status = STATUS_MISMATCH;
    end
    fields_due.push_back(rec);
    field_begin = byte_pos;
    field_len = 16'd0;
    in_quotes = 1'b0;
    if (newline) begin
      col_at = 8'd0;
      if (row_at != 16'hFFFF) row_at++;
    end else if (col_at != 8'hFF) begin
      col_at++;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (fields_due.size() == 0) begin
        errors++;
        $display("%0t unexpected record expected none actual %p", $time, out_data);
      end else begin
        oldest = fields_due.pop_front();
        check_field("row_number", 32'(oldest.row_number), 32'(out_data.row_number));
        check_field("column_number", 32'(oldest.column_number),
                    32'(out_data.column_number));
        check_field("field_offset", oldest.field_offset, out_data.field_offset);
        check_field("field_length", 32'(oldest.field_length),
                    32'(out_data.field_length));
        check_field("selected", 32'(oldest.selected), 32'(out_data.selected));
        check_field("row_end", 32'(oldest.row_end), 32'(out_data.row_end));
        check_field("status", 32'(oldest.status), 32'(out_data.status));
      end
    end
  end

  // receiver: stall in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("csv_field_splitter_core: mismatch");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eod);
    in_item_t item;
    item.data_byte = b;
    item.end_of_data = eod;
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    predict_fields(item);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_DELIMITER: sep_byte = value;
      REG_FIRST_COLUMN: win_first = value;
      REG_LAST_COLUMN: win_last = value;
      REG_ALL_COLUMNS: win_all = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_window(input logic [7:0] delim, input logic [7:0] first,
                            input logic [7:0] last, input logic all);
    write_reg(REG_DELIMITER, delim);
    write_reg(REG_FIRST_COLUMN, first);
    write_reg(REG_LAST_COLUMN, last);
    write_reg(REG_ALL_COLUMNS, {7'd0, all});
  endtask

  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 11))
      0: return 8'($urandom_range(0, 255));
      1: return QUOTE_BYTE;
      2: return sep_byte;
      default: return 8'h61 + 8'($urandom_range(0, 25));
    endcase
  endfunction

  task automatic send_random_rows(input int n_items);
    int stop_at;
    int width;
    int cols;
    int chars;
    bit quoted;
    stop_at = items_sent + n_items;
    width = $urandom_range(1, 6);
    while (items_sent < stop_at) begin
      cols = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : width;
      for (int c = 0; c < cols; c++) begin
        chars = $urandom_range(0, 5);
        quoted = ($urandom_range(0, 3) == 0);
        if (quoted) send_item(QUOTE_BYTE, 1'b0);
        for (int k = 0; k < chars; k++) send_item(text_byte(), 1'b0);
        if (quoted) send_item(QUOTE_BYTE, 1'b0);
        if ($urandom_range(0, 39) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b1);
        end else if (c == cols - 1) begin
          send_item(NEWLINE_BYTE, 1'b0);
        end else begin
          send_item(sep_byte, 1'b0);
        end
      end
    end
  endtask

  task automatic test_directed();
    send_text("ab,\"c,d\"\n");
    send_text("x\n");
    send_item(NUL_BYTE, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b1);
    send_text("\"q");
    send_item(8'h00, 1'b1);
    send_text("r\n");
  endtask

  task automatic run_with_window(input logic [7:0] delim, input logic [7:0] first,
                                 input logic [7:0] last, input logic all);
    wait_idle();
    set_window(delim, first, last, all);
    send_random_rows(30);
  endtask

  task automatic test_window_settings();
    run_with_window(QUOTE_BYTE, 8'd0, 8'd0, 1'b0);
    run_with_window(NEWLINE_BYTE, 8'd255, 8'd255, 1'b0);
    run_with_window(8'd1, 8'd3, 8'd1, 1'b0);
    run_with_window(8'd255, 8'd2, 8'd5, 1'b0);
    run_with_window(8'd9, 8'd255, 8'd0, 1'b1);
    run_with_window(8'd59, 8'd1, 8'd3, 1'b0);
    run_with_window(8'd44, 8'd0, 8'd255, 1'b1);
  endtask

  task automatic test_random_rows();
    for (int seg = 0; seg < 10; seg++) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      send_random_rows(30);
      if ($urandom_range(0, 1) == 0) begin
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
          set_window(($urandom_range(0, 2) == 0) ? 8'd44 : 8'($urandom_range(1, 255)),
                     8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                     1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  task automatic test_column_saturation();
    wait_idle();
    set_window(8'd44, 8'd250, 8'd255, 1'b0);
    for (int i = 0; i < 300; i++) send_text("x,");
    send_item(NEWLINE_BYTE, 1'b0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_window_settings();
    test_random_rows();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    test_column_saturation();
    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("csv_field_splitter_core: match");
    end else begin
      $display("csv_field_splitter_core: mismatch");
    end
    $finish;
  end

endmodule
